/* rtl/imh_pkg.sv */
package imh_pkg;

	// default sizes
	localparam int CAPACITY_DEF     = 1024;
	localparam int HANDLE_COUNT_DEF = 1024;

	// request modes
	typedef enum logic [1:0] {
		MODE_INSERT   = 2'd0,
		MODE_DECREASE = 2'd1,
		MODE_GET      = 2'd2,
		MODE_EXTRACT  = 2'd3
	} mode_t;

	// response status codes
	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_ABSENT = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	typedef struct packed {
		mode_t        mode;
		logic [31:0]  key_in;
		logic [9:0]   handle;
		logic [30:0]  decrease_by;
	} req_t;

	typedef struct packed {
		logic [31:0]  key_out;
		status_t      status;
		logic [10:0]  count;
	} rsp_t;

	// one heap slot: key and owning handle
	typedef struct packed {
		logic [31:0]  key;
		logic [9:0]   handle;
	} node_t;

	// datapath operations issued by the controller
	typedef enum logic [4:0] {
		OP_NONE,
		OP_CLR,
		OP_LATCH,
		OP_HS_RD,
		OP_ERR_ABSENT,
		OP_ERR_EMPTY,
		OP_ERR_FULL,
		OP_INS_SETUP,
		OP_DEC_RD,
		OP_DEC_LD,
		OP_RD_ONE,
		OP_TOP_GET,
		OP_EXT,
		OP_EXT_LD,
		OP_UP_RD,
		OP_UP_MOVE,
		OP_PLACE,
		OP_DN_RDL,
		OP_DN_RDR,
		OP_DN_MOVE,
		OP_RESP
	} op_t;

	// datapath status towards the controller
	typedef struct packed {
		mode_t  mode;
		logic   h_ok;
		logic   hs_hit;
		logic   hs_pos_ok;
		logic   cnt_zero;
		logic   cnt_full;
		logic   cnt_one;
		logic   at_root;
		logic   has_left;
		logic   up_less;
		logic   dn_move;
		logic   clr_last;
	} sts_t;

endpackage

/* rtl/indexed_min_heap_decrease_key_unit.sv */
// Get reads the root, insert and decrease climb towards the root, and extract
// descends from it; error responses skip the heap walk. The single read port
// of the slot memory means each level reads the parent, or the left and then
// the right child, before it compares and moves.
// Throughput: one request at a time; start is taken when busy is low.
// Reset: asynchronous, active low; then a clearing pass over the handle
// table with busy high. The receiver cannot stall results.
module indexed_min_heap_decrease_key_unit import imh_pkg::*; #(
	parameter int CAPACITY     = CAPACITY_DEF,
	parameter int HANDLE_COUNT = HANDLE_COUNT_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	output logic  busy,
	input  req_t  req,
	output logic  done,
	output rsp_t  rsp
);

	op_t   op;
	sts_t  sts;

	imh_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.busy   (busy),
		.op     (op)
	);

	imh_dp #(
		.CAPACITY     (CAPACITY),
		.HANDLE_COUNT (HANDLE_COUNT)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.req    (req),
		.sts    (sts),
		.done   (done),
		.rsp    (rsp)
	);

endmodule

/* rtl/imh_dp.sv */
module imh_dp import imh_pkg::*; #(
	parameter int CAPACITY     = CAPACITY_DEF,
	parameter int HANDLE_COUNT = HANDLE_COUNT_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	input  op_t    op,
	input  req_t   req,
	output sts_t   sts,
	output logic   done,
	output rsp_t   rsp
);

	localparam int SW = $clog2(CAPACITY + 1);
	localparam int HW = $clog2(HANDLE_COUNT);

	function automatic logic [HW-1:0] hidx(input logic [9:0] h);
		hidx = HW'(h);
	endfunction

	// memories
	node_t          nd_mem [CAPACITY + 1];
	logic [SW-1:0]  hs_mem [HANDLE_COUNT];

	req_t           req_q;
	logic [SW-1:0]  cnt_q;
	logic [SW-1:0]  pos_q;
	node_t          e_q;
	node_t          lnode_q;
	logic [31:0]    res_key_q;
	status_t        status_q;
	logic [HW-1:0]  clr_q;
	node_t          nd_rdata_q;
	logic [SW-1:0]  hs_rdata_q;
	logic           done_q;
	rsp_t           rsp_q;

	logic           nd_re, nd_we, hs_re, hs_we;
	logic [SW-1:0]  nd_raddr, nd_waddr, hs_wdata;
	node_t          nd_wdata;
	logic [HW-1:0]  hs_waddr;
	logic [SW-1:0]  lpos;
	logic           pick_r;
	node_t          pick;
	logic [32:0]    diff;
	logic [31:0]    dec_key;

	// child selection for sift-down
	assign lpos   = SW'({pos_q, 1'b0});
	assign pick_r = sts.has_left && ({pos_q, 1'b1} <= {1'b0, cnt_q}) &&
	                ($signed(lnode_q.key) > $signed(nd_rdata_q.key));
	assign pick   = pick_r ? nd_rdata_q : lnode_q;

	// saturating decrease
	assign diff    = {nd_rdata_q.key[31], nd_rdata_q.key} - {2'b00, req_q.decrease_by};
	assign dec_key = (diff[32] != diff[31]) ? 32'h8000_0000 : diff[31:0];

	// status
	assign sts.mode      = req_q.mode;
	assign sts.h_ok      = 32'(req_q.handle) < 32'(HANDLE_COUNT);
	assign sts.hs_hit    = hs_rdata_q != '0;
	assign sts.hs_pos_ok = (hs_rdata_q != '0) && (hs_rdata_q <= cnt_q);
	assign sts.cnt_zero  = cnt_q == '0;
	assign sts.cnt_full  = cnt_q == SW'(CAPACITY);
	assign sts.cnt_one   = cnt_q == SW'(1);
	assign sts.at_root   = pos_q == SW'(1);
	assign sts.has_left  = {pos_q, 1'b0} <= {1'b0, cnt_q};
	assign sts.up_less   = $signed(e_q.key) < $signed(nd_rdata_q.key);
	assign sts.dn_move   = $signed(pick.key) < $signed(e_q.key);
	assign sts.clr_last  = clr_q == HW'(HANDLE_COUNT - 1);

	// memory port control
	always_comb begin
		nd_re    = 1'b0;
		nd_raddr = '0;
		nd_we    = 1'b0;
		nd_waddr = pos_q;
		nd_wdata = e_q;
		hs_re    = 1'b0;
		hs_we    = 1'b0;
		hs_waddr = hidx(e_q.handle);
		hs_wdata = pos_q;
		unique case (op)
			OP_CLR: begin
				hs_we    = 1'b1;
				hs_waddr = clr_q;
				hs_wdata = '0;
			end
			OP_HS_RD: hs_re = 1'b1;
			OP_DEC_RD: begin
				nd_re    = 1'b1;
				nd_raddr = hs_rdata_q;
			end
			OP_RD_ONE: begin
				nd_re    = 1'b1;
				nd_raddr = SW'(1);
			end
			OP_EXT: begin
				nd_re    = 1'b1;
				nd_raddr = cnt_q;
				hs_we    = 1'b1;
				hs_waddr = hidx(nd_rdata_q.handle);
				hs_wdata = '0;
			end
			OP_UP_RD: begin
				nd_re    = 1'b1;
				nd_raddr = pos_q >> 1;
			end
			OP_UP_MOVE: begin
				nd_we    = 1'b1;
				nd_wdata = nd_rdata_q;
				hs_we    = 1'b1;
				hs_waddr = hidx(nd_rdata_q.handle);
			end
			OP_PLACE: begin
				nd_we = 1'b1;
				hs_we = 1'b1;
			end
			OP_DN_RDL: begin
				nd_re    = 1'b1;
				nd_raddr = lpos;
			end
			OP_DN_RDR: begin
				nd_re    = 1'b1;
				nd_raddr = lpos + SW'(1);
			end
			OP_DN_MOVE: begin
				nd_we    = 1'b1;
				nd_wdata = pick;
				hs_we    = 1'b1;
				hs_waddr = hidx(pick.handle);
			end
			default: ;
		endcase
	end

	// slot memory
	always_ff @(posedge clk) begin
		if (nd_we) begin
			nd_mem[nd_waddr] <= nd_wdata;
		end
		if (nd_re) begin
			nd_rdata_q <= nd_mem[nd_raddr];
		end
	end

	// handle table
	always_ff @(posedge clk) begin
		if (hs_we) begin
			hs_mem[hs_waddr] <= hs_wdata;
		end
		if (hs_re) begin
			hs_rdata_q <= hs_mem[hidx(req_q.handle)];
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			clr_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= op == OP_RESP;
			if (op == OP_CLR) begin
				clr_q <= clr_q + HW'(1);
			end
			if (op == OP_INS_SETUP) begin
				cnt_q <= cnt_q + SW'(1);
			end else if (op == OP_EXT) begin
				cnt_q <= cnt_q - SW'(1);
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (op)
			OP_LATCH: begin
				req_q     <= req;
				res_key_q <= '0;
				status_q  <= ST_OK;
			end
			OP_ERR_ABSENT: status_q <= ST_ABSENT;
			OP_ERR_EMPTY:  status_q <= ST_EMPTY;
			OP_ERR_FULL:   status_q <= ST_FULL;
			OP_INS_SETUP: begin
				pos_q      <= cnt_q + SW'(1);
				e_q.key    <= req_q.key_in;
				e_q.handle <= req_q.handle;
			end
			OP_DEC_RD: pos_q <= hs_rdata_q;
			OP_DEC_LD: begin
				e_q.key    <= dec_key;
				e_q.handle <= req_q.handle;
			end
			OP_TOP_GET: res_key_q <= nd_rdata_q.key;
			OP_EXT:     res_key_q <= nd_rdata_q.key;
			OP_EXT_LD: begin
				e_q   <= nd_rdata_q;
				pos_q <= SW'(1);
			end
			OP_UP_MOVE: pos_q <= pos_q >> 1;
			OP_DN_RDR:  lnode_q <= nd_rdata_q;
			OP_DN_MOVE: pos_q <= pick_r ? lpos + SW'(1) : lpos;
			OP_RESP: begin
				rsp_q.key_out <= (status_q == ST_OK) ? res_key_q : '0;
				rsp_q.status  <= status_q;
				rsp_q.count   <= 11'(cnt_q);
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

/* rtl/imh_ctrl.sv */
module imh_ctrl import imh_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  sts_t  sts,
	output logic  busy,
	output op_t   op
);

	typedef enum logic [13:0] {
		S_CLR     = 14'b00000000000001,
		S_IDLE    = 14'b00000000000010,
		S_DISP    = 14'b00000000000100,
		S_INS_CHK = 14'b00000000001000,
		S_DEC_CHK = 14'b00000000010000,
		S_DEC_LD  = 14'b00000000100000,
		S_UP_RD   = 14'b00000001000000,
		S_UP_CMP  = 14'b00000010000000,
		S_TOP     = 14'b00000100000000,
		S_EXT_LD  = 14'b00001000000000,
		S_DN_L    = 14'b00010000000000,
		S_DN_R    = 14'b00100000000000,
		S_DN_CMP  = 14'b01000000000000,
		S_RESP    = 14'b10000000000000
	} state_t;

	state_t state_q, state_d;

	// next state and operation
	always_comb begin
		state_d = state_q;
		op      = OP_NONE;
		unique case (state_q)
			S_CLR: begin
				op = OP_CLR;
				if (sts.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					op      = OP_LATCH;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				priority if (sts.mode == MODE_INSERT || sts.mode == MODE_DECREASE) begin
					if (!sts.h_ok) begin
						op      = OP_ERR_ABSENT;
						state_d = S_RESP;
					end else begin
						op      = OP_HS_RD;
						state_d = (sts.mode == MODE_INSERT) ? S_INS_CHK : S_DEC_CHK;
					end
				end else if (sts.cnt_zero) begin
					op      = OP_ERR_EMPTY;
					state_d = S_RESP;
				end else begin
					op      = OP_RD_ONE;
					state_d = S_TOP;
				end
			end
			S_INS_CHK: begin
				priority if (sts.hs_hit) begin
					op      = OP_ERR_ABSENT;
					state_d = S_RESP;
				end else if (sts.cnt_full) begin
					op      = OP_ERR_FULL;
					state_d = S_RESP;
				end else begin
					op      = OP_INS_SETUP;
					state_d = S_UP_RD;
				end
			end
			S_DEC_CHK: begin
				if (!sts.hs_pos_ok) begin
					op      = OP_ERR_ABSENT;
					state_d = S_RESP;
				end else begin
					op      = OP_DEC_RD;
					state_d = S_DEC_LD;
				end
			end
			S_DEC_LD: begin
				op      = OP_DEC_LD;
				state_d = S_UP_RD;
			end
			S_UP_RD: begin
				if (sts.at_root) begin
					op      = OP_PLACE;
					state_d = S_RESP;
				end else begin
					op      = OP_UP_RD;
					state_d = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				if (sts.up_less) begin
					op      = OP_UP_MOVE;
					state_d = S_UP_RD;
				end else begin
					op      = OP_PLACE;
					state_d = S_RESP;
				end
			end
			S_TOP: begin
				if (sts.mode == MODE_GET) begin
					op      = OP_TOP_GET;
					state_d = S_RESP;
				end else begin
					op      = OP_EXT;
					state_d = sts.cnt_one ? S_RESP : S_EXT_LD;
				end
			end
			S_EXT_LD: begin
				op      = OP_EXT_LD;
				state_d = S_DN_L;
			end
			S_DN_L: begin
				if (!sts.has_left) begin
					op      = OP_PLACE;
					state_d = S_RESP;
				end else begin
					op      = OP_DN_RDL;
					state_d = S_DN_R;
				end
			end
			S_DN_R: begin
				op      = OP_DN_RDR;
				state_d = S_DN_CMP;
			end
			S_DN_CMP: begin
				if (sts.dn_move) begin
					op      = OP_DN_MOVE;
					state_d = S_DN_L;
				end else begin
					op      = OP_PLACE;
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				op      = OP_RESP;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = state_q != S_IDLE;

endmodule

/* rtl/imh_checker.sv */
module imh_checker import imh_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  logic  busy,
	input  logic  done,
	input  rsp_t  rsp
);

	// an accepted request keeps the unit busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("not busy after accepted request");

	// one strobe per request
	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("response strobe repeated");

	// errors report a zero key
	a_err_key: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status != ST_OK) |-> rsp.key_out == '0)
		else $error("error response with non-zero key");

	// empty status only with an empty heap
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status == ST_EMPTY) |-> rsp.count == '0)
		else $error("empty status with entries present");

endmodule

bind indexed_min_heap_decrease_key_unit imh_checker u_imh_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);
